// ----- hw/rtl/mandelbrot_escape_colour_top_assert.svh -----
// Assertion macros for the escape-time colour block.
// Taken in by the top level with `include; no other dependencies.
`ifndef MANDELBROT_ESCAPE_COLOUR_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_COLOUR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mec_pkg.sv -----
// Shared constants, types and codes for the escape-time colour block.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
package mec_pkg;

    // sizing
    localparam int PALETTE_DEPTH = 256;
    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 28;
    localparam int Q_BITS        = 32;
    localparam int PROD_BITS     = 2 * Q_BITS;
    localparam int PAL_ADDR_BITS = $clog2(PALETTE_DEPTH);
    localparam int PAL_IDX_BITS  = 8;
    localparam int COLOUR_BITS   = 8;
    localparam int COUNT_BITS    = 16;
    localparam int ROW_W_BITS    = 13;
    localparam int PAL_LEN_BITS  = 9;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // |z|^2 >= 4.0 on the exact Q.2F sum of squares
    localparam int ESC_SHIFT = 2 + 2 * FRAC_BITS;
    localparam bit ESC_ON    = (ESC_SHIFT < PROD_BITS);
    localparam logic [PROD_BITS-1:0] ESC_LIM =
        ESC_ON ? (PROD_BITS'(1) << ESC_SHIFT) : '0;

    typedef logic signed [Q_BITS-1:0] t_q;

    // item operation codes
    localparam logic OP_PAL_WRITE = 1'b0;
    localparam logic OP_RENDER    = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROW_WIDTH  = 3'd0,
        CFG_MAX_ITER   = 3'd1,
        CFG_PAL_LEN    = 3'd2,
        CFG_BEGIN_REAL = 3'd3,
        CFG_BEGIN_IMAG = 3'd4,
        CFG_STEP_REAL  = 3'd5,
        CFG_STEP_IMAG  = 3'd6
    } t_cfg_idx;

    // register reset values
    localparam logic [ROW_W_BITS-1:0]   RST_ROW_WIDTH  = 13'd80;
    localparam logic [COUNT_BITS-1:0]   RST_MAX_ITER   = 16'd256;
    localparam logic [PAL_LEN_BITS-1:0] RST_PAL_LEN    = 9'd256;
    localparam t_q                      RST_BEGIN_REAL = -32'sd579820749;
    localparam t_q                      RST_BEGIN_IMAG = 32'sd402653184;
    localparam t_q                      RST_STEP_REAL  = 32'sd8947848;
    localparam t_q                      RST_STEP_IMAG  = -32'sd29826161;

    typedef struct packed {
        logic [ROW_W_BITS-1:0]   row_width;
        logic [COUNT_BITS-1:0]   max_iter;
        logic [PAL_LEN_BITS-1:0] pal_len;
        t_q                      begin_real;
        t_q                      begin_imag;
        t_q                      step_real;
        t_q                      step_imag;
    } t_cfg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_POINT,
        ST_SQUARE,
        ST_UPDATE,
        ST_READ,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic pal_write;
        logic load_item;
        logic coord_mul;
        logic point_init;
        logic sq_mul;
        logic update;
        logic cnt_clear;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic at_limit;
        logic escaped;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hw/rtl/mec_in_if.sv -----
// Input channel: pixel render and colour table write items.
// Depends on mec_pkg for field widths.
`timescale 1ns / 1ps
interface mec_in_if import mec_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [COORD_BITS-1:0]    pixel_x;
    logic [COORD_BITS-1:0]    pixel_y;
    logic [PAL_IDX_BITS-1:0]  palette_index;
    logic [COLOUR_BITS-1:0]   palette_value;

    modport source (output valid, op, pixel_x, pixel_y, palette_index, palette_value,
                    input ready);
    modport sink   (input valid, op, pixel_x, pixel_y, palette_index, palette_value,
                    output ready);
endinterface

// ----- hw/rtl/mec_out_if.sv -----
// Result channel: colour, escape count and row-end flag per rendered pixel.
// Depends on mec_pkg for field widths.
`timescale 1ns / 1ps
interface mec_out_if import mec_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [COLOUR_BITS-1:0]  colour;
    logic [COUNT_BITS-1:0]   iter_count;
    logic                    row_end;

    modport source (output valid, colour, iter_count, row_end, input ready);
    modport sink   (input valid, colour, iter_count, row_end, output ready);
endinterface

// ----- hw/rtl/mandelbrot_escape_colour_top.sv -----
// Escape-time renderer with a 256-entry colour table. A render transfer gives a
// pixel column and row; the block forms c = begin + (column*step_real,
// row*step_imag) in Q4.28 and iterates z = z*z + c until |z|^2 >= 4 or the
// iteration limit. In each round the three 32x32 products are registered, then
// the escape test and the saturating update run. The next item is taken once
// the result sits in the output register, even while it waits there. A table
// write transfer gives no result. The table needs no clearing after reset, but
// an entry must be written before any pixel selects it.
//
// Holds the configuration registers and joins controller and datapath.
// Depends on mec_pkg, mec_in_if, mec_out_if, mec_ctrl, mec_dp and the assert header.
`timescale 1ns / 1ps
`include "mandelbrot_escape_colour_top_assert.svh"
module mandelbrot_escape_colour_top import mec_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    mec_in_if.sink                    i_pix,
    mec_out_if.source                 o_res
);

    t_cfg       r_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width  <= RST_ROW_WIDTH;
            r_cfg.max_iter   <= RST_MAX_ITER;
            r_cfg.pal_len    <= RST_PAL_LEN;
            r_cfg.begin_real <= RST_BEGIN_REAL;
            r_cfg.begin_imag <= RST_BEGIN_IMAG;
            r_cfg.step_real  <= RST_STEP_REAL;
            r_cfg.step_imag  <= RST_STEP_IMAG;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_WIDTH:  r_cfg.row_width  <= i_cfg_data[ROW_W_BITS-1:0];
                CFG_MAX_ITER:   r_cfg.max_iter   <= i_cfg_data[COUNT_BITS-1:0];
                CFG_PAL_LEN:    r_cfg.pal_len    <= i_cfg_data[PAL_LEN_BITS-1:0];
                CFG_BEGIN_REAL: r_cfg.begin_real <= t_q'(i_cfg_data[Q_BITS-1:0]);
                CFG_BEGIN_IMAG: r_cfg.begin_imag <= t_q'(i_cfg_data[Q_BITS-1:0]);
                CFG_STEP_REAL:  r_cfg.step_real  <= t_q'(i_cfg_data[Q_BITS-1:0]);
                CFG_STEP_IMAG:  r_cfg.step_imag  <= t_q'(i_cfg_data[Q_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // sequencer
    mec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_in_op    (i_pix.op),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_pix.ready = w_in_ready;

    // arithmetic, table and result register
    mec_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (w_cmd),
        .i_pixel_x       (i_pix.pixel_x),
        .i_pixel_y       (i_pix.pixel_y),
        .i_palette_index (i_pix.palette_index),
        .i_palette_value (i_pix.palette_value),
        .o_status        (w_status),
        .o_res           (o_res)
    );

    // checks
    `MEC_ASSERT_IMP(a_zero_count_colour, i_clk, i_rst_n, o_res.valid && (o_res.iter_count == '0), o_res.colour == '0, "count zero with nonzero colour")
    `MEC_ASSERT_NXT(a_render_busy, i_clk, i_rst_n, i_pix.valid && i_pix.ready && (i_pix.op == OP_RENDER), !i_pix.ready, "input still ready after render transfer")
    `MEC_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, w_cmd.out_load, o_res.valid, "result load did not raise valid")

endmodule

// ----- hw/rtl/mec_ctrl.sv -----
// Sequencer for one pixel: point set-up, square/update rounds, table read, result.
// Depends on mec_pkg for state, command and status types.
`timescale 1ns / 1ps
module mec_ctrl import mec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_in_op == OP_RENDER)) begin
                    n_state = ST_COORD;
                end
            end
            ST_COORD:  n_state = ST_POINT;
            ST_POINT:  n_state = ST_SQUARE;
            ST_SQUARE: begin
                n_state = i_status.at_limit ? ST_READ : ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_status.escaped ? ST_READ : ST_SQUARE;
            end
            ST_READ:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_PAL_WRITE) begin
                        o_cmd.pal_write = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                    end
                end
            end
            ST_COORD:  o_cmd.coord_mul  = 1'b1;
            ST_POINT:  o_cmd.point_init = 1'b1;
            ST_SQUARE: begin
                if (i_status.at_limit) begin
                    o_cmd.cnt_clear = 1'b1;
                end else begin
                    o_cmd.sq_mul = 1'b1;
                end
            end
            ST_UPDATE: begin
                // escape ends the pixel with the current count
                o_cmd.update = !i_status.escaped;
            end
            ST_READ:   o_cmd = '0;
            ST_DONE:   o_cmd.out_load = i_status.out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/mec_dp.sv -----
// Datapath: point forming, Q4.28 complex square and add, colour table, result register.
// Depends on mec_pkg and the mec_out_if result channel.
`timescale 1ns / 1ps
module mec_dp import mec_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_dp_cmd                  i_cmd,
    input  logic [COORD_BITS-1:0]    i_pixel_x,
    input  logic [COORD_BITS-1:0]    i_pixel_y,
    input  logic [PAL_IDX_BITS-1:0]  i_palette_index,
    input  logic [COLOUR_BITS-1:0]   i_palette_value,
    output t_dp_status               o_status,
    mec_out_if.source                o_res
);

    // clamp a wide signed value to the Q4.28 range
    function automatic t_q sat_q(input logic signed [PROD_BITS-1:0] v);
        logic [PROD_BITS-Q_BITS:0] upper;
        upper = v[PROD_BITS-1:Q_BITS-1];
        if ((&upper) || !(|upper)) begin
            return v[Q_BITS-1:0];
        end else if (v[PROD_BITS-1]) begin
            return {1'b1, {(Q_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_BITS-1){1'b1}}};
        end
    endfunction

    logic [COORD_BITS-1:0]         r_px;
    logic [COORD_BITS-1:0]         r_py;
    logic                          r_row_end;
    t_q                            r_cr;
    t_q                            r_ci;
    t_q                            r_zr;
    t_q                            r_zi;
    logic signed [PROD_BITS-1:0]   r_prr;
    logic signed [PROD_BITS-1:0]   r_pii;
    logic signed [PROD_BITS-1:0]   r_pri;
    logic [COUNT_BITS-1:0]         r_n;
    logic [PAL_ADDR_BITS-1:0]      r_mod;
    logic [COLOUR_BITS-1:0]        r_rd;
    logic [COLOUR_BITS-1:0]        r_pal_mem [PALETTE_DEPTH];
    logic                          r_out_valid;
    logic [COLOUR_BITS-1:0]        r_out_colour;
    logic [COUNT_BITS-1:0]         r_out_count;
    logic                          r_out_row_end;

    t_q                            w_ma_r;
    t_q                            w_mb_r;
    t_q                            w_ma_i;
    t_q                            w_mb_i;
    logic signed [PROD_BITS-1:0]   w_prr;
    logic signed [PROD_BITS-1:0]   w_pii;
    logic signed [PROD_BITS-1:0]   w_pri;
    logic [PROD_BITS-1:0]          w_sq_sum;
    logic signed [PROD_BITS-1:0]   w_diff;
    logic signed [PROD_BITS-1:0]   w_nr;
    logic signed [PROD_BITS-1:0]   w_ni;
    logic signed [PROD_BITS-1:0]   w_cr_wide;
    logic signed [PROD_BITS-1:0]   w_ci_wide;
    logic [PAL_LEN_BITS-1:0]       w_len;
    logic [PAL_ADDR_BITS-1:0]      w_div;
    logic [PAL_ADDR_BITS-1:0]      w_mod_next;
    logic                          w_out_free;

    // multiplier operands: coordinate times step during set-up, z terms otherwise
    assign w_ma_r = i_cmd.coord_mul ? t_q'({{(Q_BITS-COORD_BITS){1'b0}}, r_px}) : r_zr;
    assign w_mb_r = i_cmd.coord_mul ? i_cfg.step_real : r_zr;
    assign w_ma_i = i_cmd.coord_mul ? t_q'({{(Q_BITS-COORD_BITS){1'b0}}, r_py}) : r_zi;
    assign w_mb_i = i_cmd.coord_mul ? i_cfg.step_imag : r_zi;
    assign w_prr  = w_ma_r * w_mb_r;
    assign w_pii  = w_ma_i * w_mb_i;
    assign w_pri  = r_zr * r_zi;

    // point from registered coordinate products
    assign w_cr_wide = PROD_BITS'(i_cfg.begin_real) + r_prr;
    assign w_ci_wide = PROD_BITS'(i_cfg.begin_imag) + r_pii;

    // escape test and next z from registered squares
    assign w_sq_sum = $unsigned(r_prr) + $unsigned(r_pii);
    assign w_diff   = r_prr - r_pii;
    assign w_nr     = (w_diff >>> FRAC_BITS) + PROD_BITS'(r_cr);
    assign w_ni     = (r_pri >>> (FRAC_BITS - 1)) + PROD_BITS'(r_ci);

    // table divisor: clamped length minus one; running remainder of the count
    always_comb begin
        if (i_cfg.pal_len < PAL_LEN_BITS'(2)) begin
            w_len = PAL_LEN_BITS'(2);
        end else if (i_cfg.pal_len > PAL_LEN_BITS'(PALETTE_DEPTH)) begin
            w_len = PAL_LEN_BITS'(PALETTE_DEPTH);
        end else begin
            w_len = i_cfg.pal_len;
        end
    end
    assign w_div      = PAL_ADDR_BITS'(w_len - PAL_LEN_BITS'(1));
    assign w_mod_next = ((PAL_ADDR_BITS+1)'(r_mod) + (PAL_ADDR_BITS+1)'(1)
                         == {1'b0, w_div}) ? '0 : r_mod + PAL_ADDR_BITS'(1);

    assign w_out_free = !r_out_valid || o_res.ready;

    assign o_status.at_limit = (r_n == i_cfg.max_iter);
    assign o_status.escaped  = ESC_ON && (w_sq_sum >= ESC_LIM);
    assign o_status.out_free = w_out_free;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_px      <= i_pixel_x;
            r_py      <= i_pixel_y;
            r_row_end <= (ROW_W_BITS'(i_pixel_x) + ROW_W_BITS'(1) == i_cfg.row_width);
        end
    end

    // product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.coord_mul || i_cmd.sq_mul) begin
            r_prr <= w_prr;
            r_pii <= w_pii;
            r_pri <= w_pri;
        end
    end

    // point, z, count and remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.point_init) begin
            r_cr  <= sat_q(w_cr_wide);
            r_ci  <= sat_q(w_ci_wide);
            r_zr  <= sat_q(w_cr_wide);
            r_zi  <= sat_q(w_ci_wide);
            r_n   <= '0;
            r_mod <= '0;
        end else if (i_cmd.update) begin
            r_zr  <= sat_q(w_nr);
            r_zi  <= sat_q(w_ni);
            r_n   <= r_n + COUNT_BITS'(1);
            r_mod <= w_mod_next;
        end else if (i_cmd.cnt_clear) begin
            r_n   <= '0;
        end
    end

    // colour table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_write &&
            ((PAL_IDX_BITS+1)'(i_palette_index) < (PAL_IDX_BITS+1)'(PALETTE_DEPTH))) begin
            r_pal_mem[PAL_ADDR_BITS'(i_palette_index)] <= i_palette_value;
        end
        r_rd <= r_pal_mem[r_mod];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_colour  <= (r_n == '0) ? '0 : r_rd;
            r_out_count   <= r_n;
            r_out_row_end <= r_row_end;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.colour     = r_out_colour;
    assign o_res.iter_count = r_out_count;
    assign o_res.row_end    = r_out_row_end;

endmodule

// ----- tb/mandelbrot_escape_colour_top_tb.sv -----
// Self-checking bench for the escape-time colour block: random render and table
// write transfers with a per-transfer predictor and an in-order result check.
// Depends on mec_pkg, mec_in_if, mec_out_if and mandelbrot_escape_colour_top.
`timescale 1ns / 1ps
module mandelbrot_escape_colour_top_tb;
    import mec_pkg::*;

    localparam int     ITEM_TARGET = 1300;
    localparam int     HOLD_CYCLES = 400;
    localparam longint Q_HI        = 64'sd2147483647;
    localparam longint Q_LO        = -64'sd2147483648;

    typedef struct packed {
        logic                    op;
        logic [COORD_BITS-1:0]   px;
        logic [COORD_BITS-1:0]   py;
        logic [PAL_IDX_BITS-1:0] slot;
        logic [COLOUR_BITS-1:0]  shade;
    } pix_item_t;

    typedef struct packed {
        logic [COLOUR_BITS-1:0] colour;
        logic [COUNT_BITS-1:0]  count;
        logic                   row_end;
    } pix_result_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    mec_in_if  pix_if ();
    mec_out_if res_if ();

    mandelbrot_escape_colour_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source)
    );

    // predictor state and bench bookkeeping
    t_cfg                   cfg_shadow;
    logic [COLOUR_BITS-1:0] colour_shadow [PALETTE_DEPTH];
    bit                     entry_loaded [PALETTE_DEPTH];
    pix_item_t              items_to_send [$];
    pix_result_t            expected_pixels [$];
    pix_item_t              offered;
    pix_result_t            due;
    bit                     offering;
    bit                     src_gaps;
    bit                     snk_gaps;
    bit                     hold_go;
    bit                     hold_done;
    int                     hold_left;
    int                     mismatches;
    int                     sent_items;
    longint                 run_budget;
    longint                 cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat_q(longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // escape count of one pixel under the current settings
    function automatic logic [COUNT_BITS-1:0] escape_rounds(logic [COORD_BITS-1:0] px,
                                                            logic [COORD_BITS-1:0] py);
        longint      cr, ci, zr, zi, nr, ni;
        logic [63:0] mag;
        int unsigned lim, n;
        cr = sat_q(longint'($signed(cfg_shadow.begin_real))
                   + longint'(px) * longint'($signed(cfg_shadow.step_real)));
        ci = sat_q(longint'($signed(cfg_shadow.begin_imag))
                   + longint'(py) * longint'($signed(cfg_shadow.step_imag)));
        lim = cfg_shadow.max_iter;
        zr  = cr;
        zi  = ci;
        for (n = 0; n < lim; n++) begin
            mag = zr * zr + zi * zi;
            if (mag >= ESC_LIM) break;
            nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
            ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
            zr = sat_q(nr);
            zi = sat_q(ni);
        end
        return (n == lim) ? '0 : COUNT_BITS'(n);
    endfunction

    // table entry picked by a non-zero count; length clamped to 2..depth
    function automatic logic [PAL_ADDR_BITS-1:0] colour_slot(logic [COUNT_BITS-1:0] n);
        int unsigned len;
        len = cfg_shadow.pal_len;
        if (len < 2) len = 2;
        if (len > PALETTE_DEPTH) len = PALETTE_DEPTH;
        return PAL_ADDR_BITS'(n % (len - 1));
    endfunction

    // expected outcome of one accepted transfer
    function automatic void predict_pixel(pix_item_t it);
        pix_result_t r;
        if (it.op == OP_PAL_WRITE) begin
            colour_shadow[it.slot] = it.shade;
            return;
        end
        r.count   = escape_rounds(it.px, it.py);
        r.colour  = (r.count == 0) ? '0 : colour_shadow[colour_slot(r.count)];
        r.row_end = (int'(it.px) + 1 == int'(cfg_shadow.row_width));
        expected_pixels.push_back(r);
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic queue_table_write(logic [PAL_IDX_BITS-1:0] idx,
                                     logic [COLOUR_BITS-1:0] val);
        pix_item_t it;
        it.op    = OP_PAL_WRITE;
        it.px    = COORD_BITS'($urandom);
        it.py    = COORD_BITS'($urandom);
        it.slot  = idx;
        it.shade = val;
        entry_loaded[idx] = 1'b1;
        items_to_send.push_back(it);
        sent_items++;
        run_budget += 40;
    endtask

    // a render, preceded by a table write if it would pick a fresh entry
    task automatic queue_render(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
        pix_item_t              it;
        logic [COUNT_BITS-1:0]  n;
        logic [PAL_ADDR_BITS-1:0] s;
        n = escape_rounds(px, py);
        if (n != 0) begin
            s = colour_slot(n);
            if (!entry_loaded[s]) queue_table_write(s, COLOUR_BITS'($urandom));
        end
        it.op    = OP_RENDER;
        it.px    = px;
        it.py    = py;
        it.slot  = PAL_IDX_BITS'($urandom);
        it.shade = COLOUR_BITS'($urandom);
        items_to_send.push_back(it);
        sent_items++;
        run_budget += 2 * longint'(cfg_shadow.max_iter) + 60;
    endtask

    task automatic queue_random_item();
        logic [COORD_BITS-1:0] px;
        if ($urandom_range(99) < 10) begin
            queue_table_write(PAL_IDX_BITS'($urandom), COLOUR_BITS'($urandom));
        end else begin
            px = COORD_BITS'($urandom);
            if ($urandom_range(99) < 15) px = COORD_BITS'(cfg_shadow.row_width - 1);
            queue_render(px, COORD_BITS'($urandom));
        end
    endtask

    // register write, only ever issued while the block is idle
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_ROW_WIDTH:  cfg_shadow.row_width  = val[ROW_W_BITS-1:0];
            CFG_MAX_ITER:   cfg_shadow.max_iter   = val[COUNT_BITS-1:0];
            CFG_PAL_LEN:    cfg_shadow.pal_len    = val[PAL_LEN_BITS-1:0];
            CFG_BEGIN_REAL: cfg_shadow.begin_real = val;
            CFG_BEGIN_IMAG: cfg_shadow.begin_imag = val;
            CFG_STEP_REAL:  cfg_shadow.step_real  = val;
            CFG_STEP_IMAG:  cfg_shadow.step_imag  = val;
            default: ;
        endcase
    endtask

    // edge settings of each register
    function automatic logic [CFG_DATA_BITS-1:0] corner_value(t_cfg_idx r, int unsigned sel);
        case (r)
            CFG_ROW_WIDTH:
                case (sel % 4)
                    0: return 32'd0;
                    1: return 32'd1;
                    2: return 32'd4096;
                    default: return 32'd8191;
                endcase
            CFG_MAX_ITER:
                case (sel % 3)
                    0: return 32'd0;
                    1: return 32'd1;
                    default: return 32'd2;
                endcase
            CFG_PAL_LEN:
                case (sel % 6)
                    0: return 32'd0;
                    1: return 32'd1;
                    2: return 32'd257;
                    3: return 32'd511;
                    4: return 32'd2;
                    default: return 32'd256;
                endcase
            default:
                case (sel % 4)
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'd0;
                    default: return 32'd1;
                endcase
        endcase
    endfunction

    // ordinary settings: a window over the set, steps spanning a few units
    function automatic logic [CFG_DATA_BITS-1:0] typical_value(t_cfg_idx r);
        int mag;
        case (r)
            CFG_ROW_WIDTH:  return $urandom_range(1, 4096);
            CFG_MAX_ITER:
                return ($urandom_range(5) == 0) ? $urandom_range(100, 600)
                                                : $urandom_range(1, 120);
            CFG_PAL_LEN:    return $urandom_range(2, 256);
            CFG_BEGIN_REAL:
                if ($urandom_range(9) == 0) return $urandom;
                else return 32'(int'($urandom_range(0, 671088640)) - 603979776);
            CFG_BEGIN_IMAG:
                if ($urandom_range(9) == 0) return $urandom;
                else return 32'(int'($urandom_range(0, 671088640)) - 335544320);
            default: begin
                if ($urandom_range(9) == 0) return $urandom;
                mag = ($urandom_range(3) == 0) ? $urandom_range(2000)
                                                : $urandom_range(196608);
                return $urandom_range(1) ? 32'(-mag) : 32'(mag);
            end
        endcase
    endfunction

    task automatic program_phase(int k);
        t_cfg_idx r;
        r = r.first();
        do begin
            if (k < 4)
                write_reg(r, corner_value(r, k + int'(r)));
            else if ($urandom_range(99) < 15)
                write_reg(r, corner_value(r, $urandom));
            else
                write_reg(r, typical_value(r));
            r = r.next();
        end while (r != r.first());
    endtask

    task automatic drain();
        while (items_to_send.size() != 0 || offering || expected_pixels.size() != 0)
            @(negedge i_clk);
        // a table write may still be in flight after the last result
        repeat (16) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ROW_WIDTH;
        i_cfg_data    = '0;
        pix_if.valid  = 1'b0;
        pix_if.op     = OP_RENDER;
        pix_if.pixel_x       = '0;
        pix_if.pixel_y       = '0;
        pix_if.palette_index = '0;
        pix_if.palette_value = '0;
        res_if.ready  = 1'b0;
        offering      = 1'b0;
        src_gaps      = 1'b1;
        snk_gaps      = 1'b1;
        hold_go       = 1'b0;
        hold_done     = 1'b0;
        hold_left     = 0;
        mismatches    = 0;
        sent_items    = 0;
        run_budget    = 2000;
        cycles        = 0;
        cfg_shadow.row_width  = RST_ROW_WIDTH;
        cfg_shadow.max_iter   = RST_MAX_ITER;
        cfg_shadow.pal_len    = RST_PAL_LEN;
        cfg_shadow.begin_real = RST_BEGIN_REAL;
        cfg_shadow.begin_imag = RST_BEGIN_IMAG;
        cfg_shadow.step_real  = RST_STEP_REAL;
        cfg_shadow.step_imag  = RST_STEP_IMAG;
        foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, table edges, row end, corners of the grid
        queue_table_write(8'd0, 8'hFF);
        queue_table_write(8'd255, 8'h00);
        queue_table_write(8'd170, 8'h55);
        queue_table_write(8'd85, 8'hAA);
        queue_render(12'd0, 12'd0);
        queue_render(12'd4095, 12'd4095);
        queue_render(12'd79, 12'd0);
        queue_render(12'd80, 12'd13);
        queue_render(12'd4095, 12'd0);
        queue_render(12'd0, 12'd4095);
        queue_render(12'd40, 12'd13);
        queue_render(12'd60, 12'd10);
        queue_render(12'd2730, 12'd1365);
        queue_render(12'd1365, 12'd2730);
        drain();

        for (int k = 0; sent_items < ITEM_TARGET; k++) begin
            if (k == 6) begin
                // deep run: c = 0 never escapes, c = 1 escapes after one round,
                // c = 2 at once
                write_reg(CFG_MAX_ITER, 32'd65535);
                write_reg(CFG_BEGIN_REAL, 32'd0);
                write_reg(CFG_BEGIN_IMAG, 32'd0);
                write_reg(CFG_STEP_REAL, 32'h1000_0000);
                write_reg(CFG_STEP_IMAG, 32'd0);
                queue_render(12'd0, COORD_BITS'($urandom));
                queue_render(12'd1, COORD_BITS'($urandom));
                queue_render(12'd2, COORD_BITS'($urandom));
            end else begin
                program_phase(k);
                src_gaps = (k != 7);
                snk_gaps = (k != 7);
                repeat ((k < 4) ? 15 : (k == 7) ? 80 : 40) queue_random_item();
                if (k == 5) begin
                    run_budget += HOLD_CYCLES;
                    hold_go = 1'b1;
                end
            end
            run_budget += 800;
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // sender: hold each transfer until taken, random gaps between
    always @(negedge i_clk) begin
        if (i_rst_n && !offering && items_to_send.size() != 0
            && !(src_gaps && $urandom_range(99) < 35)) begin
            offered  = items_to_send.pop_front();
            offering = 1'b1;
        end
        pix_if.valid         <= offering;
        pix_if.op            <= offered.op;
        pix_if.pixel_x       <= offered.px;
        pix_if.pixel_y       <= offered.py;
        pix_if.palette_index <= offered.slot;
        pix_if.palette_value <= offered.shade;
    end

    // receiver: random stalls, plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(snk_gaps && $urandom_range(99) < 35);
        end
    end

    // check results, then record the accepted input transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    flag_mismatch("unexpected result, count", res_if.iter_count, 0);
                end else begin
                    due = expected_pixels.pop_front();
                    if (res_if.colour !== due.colour)
                        flag_mismatch("colour", res_if.colour, due.colour);
                    if (res_if.iter_count !== due.count)
                        flag_mismatch("iteration count", res_if.iter_count, due.count);
                    if (res_if.row_end !== due.row_end)
                        flag_mismatch("row end", res_if.row_end, due.row_end);
                end
            end
            if (pix_if.valid && pix_if.ready) begin
                predict_pixel(offered);
                offering = 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 4 * run_budget + 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
